// ===== design/atsf_pkg.sv =====
package atsf_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned CodeWidth  = 32;
  localparam int unsigned NumSlots   = 3;

  localparam logic [CodeWidth-1:0] SpaceCode   = 32'h0000_0020;
  localparam logic [CodeWidth-1:0] NewlineCode = 32'h0000_000A;
  localparam logic [CodeWidth-1:0] AlefCode    = 32'h0000_D8A7;
  localparam logic [CodeWidth-1:0] HamzaCode   = 32'h0000_D8A1;
  localparam logic [CodeWidth-1:0] NoonCode    = 32'h0000_D986;
  localparam logic [CodeWidth-1:0] YehCode     = 32'h0000_D98A;
  localparam logic [CodeWidth-1:0] QafCode     = 32'h0000_D982;
  localparam logic [CodeWidth-1:0] BehCode     = 32'h0000_D8A8;
  localparam logic [CodeWidth-1:0] HehCode     = 32'h0000_D987;

  typedef enum logic [1:0] {
    KIND_EMIT,
    KIND_SPACE,
    KIND_NEWLINE,
    KIND_DROP
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [CodeWidth-1:0] code;
  } class_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic                 term;
    logic [31:0]          count;
  } res_t;

  typedef struct packed {
    res_t [NumSlots-1:0] slot;
    logic [1:0]          cnt;
  } batch_t;

endpackage

// ===== design/atsf_classify.sv =====
module atsf_classify (
  input  logic [atsf_pkg::CodeWidth-1:0] code_i,
  output atsf_pkg::class_t               class_o
);
  import atsf_pkg::*;

  logic [CodeWidth-1:0] c;
  logic is_alef, is_noon, is_yeh, is_heh, is_haraka;

  assign c = code_i;

  assign is_alef = (c == 32'hD8A7) || (c == 32'hD8A2) || (c == 32'hD8A3) ||
                   (c == 32'hD8A5) || (c == 32'hD9B1) || (c == 32'hD9B2) ||
                   (c == 32'hD9B3);
  assign is_noon = (c >= 32'hDAB9) && (c <= 32'hDABD);
  assign is_yeh  = (c == 32'hD98A) || (c == 32'hD8A0) ||
                   ((c >= 32'hD8BD) && (c <= 32'hD8BF)) ||
                   ((c >= 32'hDB8C) && (c <= 32'hDB8E)) ||
                   (c == 32'hDB90) || (c == 32'hDB91);
  assign is_heh  = (c == 32'hDABE) || ((c >= 32'hDB80) && (c <= 32'hDB82)) ||
                   (c == 32'hD8A9);
  assign is_haraka = ((c >= 32'hD890) && (c <= 32'hD89A)) ||
                     ((c >= 32'hD98B) && (c <= 32'hD99F));

  // priority follows the folding order
  always_comb begin
    class_o.kind = KIND_EMIT;
    class_o.code = c;
    if (is_alef) begin
      class_o.code = AlefCode;
    end else if (c == 32'hD8A4) begin
      class_o.code = HamzaCode;
    end else if (is_noon) begin
      class_o.code = NoonCode;
    end else if (is_yeh) begin
      class_o.code = YehCode;
    end else if (c == 32'hD9AF) begin
      class_o.code = QafCode;
    end else if (c == 32'hD9AE) begin
      class_o.code = BehCode;
    end else if (is_heh) begin
      class_o.code = HehCode;
    end else if (c == SpaceCode) begin
      class_o.kind = KIND_SPACE;
    end else if (c == NewlineCode) begin
      class_o.kind = KIND_NEWLINE;
    end else if (is_haraka) begin
      class_o.kind = KIND_DROP;
    end
  end

endmodule

// ===== design/atsf_core.sv =====
module atsf_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [atsf_pkg::CodeWidth-1:0] in_code_i,
  input  logic                           in_eot_i,
  input  logic                           free_i,
  output logic                           load_o,
  output atsf_pkg::batch_t               batch_o
);
  import atsf_pkg::*;

  logic                  valid_q;
  logic [CodeWidth-1:0]  code_q;
  logic                  eot_q;
  logic                  pending_q, pending_d;
  logic                  emitted_q, emitted_d;
  logic                  newline_q, newline_d;
  logic [CountWidth-1:0] total_q, total_d;
  class_t                cls;
  logic [63:0]           total_wide;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == '1) ? v : v + CountWidth'(1);
  endfunction

  atsf_classify u_classify (
    .code_i  (code_q),
    .class_o (cls)
  );

  assign in_ready_o = !valid_q || free_i;
  assign load_o     = valid_q && free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q <= in_code_i;
      eot_q  <= in_eot_i;
    end
  end

  always_comb begin
    logic [1:0] n;
    n          = 2'd0;
    batch_o    = '0;
    pending_d  = pending_q;
    emitted_d  = emitted_q;
    newline_d  = newline_q;
    total_d    = total_q;
    total_wide = '0;
    case (cls.kind)
      KIND_EMIT: begin
        if (pending_d) begin
          batch_o.slot[n] = '{code: SpaceCode, term: 1'b0, count: 32'd0};
          n = n + 2'd1;
          total_d = sat_inc(total_d);
          pending_d = 1'b0;
        end
        batch_o.slot[n] = '{code: cls.code, term: 1'b0, count: 32'd0};
        n = n + 2'd1;
        total_d = sat_inc(total_d);
        emitted_d = 1'b1;
        newline_d = (cls.code == NewlineCode);
      end
      KIND_NEWLINE: begin
        // a held space before a newline is thrown away
        pending_d = 1'b0;
        batch_o.slot[n] = '{code: NewlineCode, term: 1'b0, count: 32'd0};
        n = n + 2'd1;
        total_d = sat_inc(total_d);
        emitted_d = 1'b1;
        newline_d = 1'b1;
      end
      KIND_SPACE: begin
        if (emitted_d && !pending_d && !newline_d) begin
          pending_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (eot_q) begin
      if (pending_d) begin
        batch_o.slot[n] = '{code: SpaceCode, term: 1'b0, count: 32'd0};
        n = n + 2'd1;
        total_d = sat_inc(total_d);
      end
      total_wide = 64'(total_d);
      batch_o.slot[n] = '{code: '0, term: 1'b1,
                          count: (total_wide > 64'h0000_0000_FFFF_FFFF) ?
                                 32'hFFFF_FFFF : total_wide[31:0]};
      n = n + 2'd1;
      pending_d = 1'b0;
      emitted_d = 1'b0;
      newline_d = 1'b0;
      total_d   = '0;
    end
    batch_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      emitted_q <= 1'b0;
      newline_q <= 1'b0;
      total_q   <= '0;
    end else if (load_o) begin
      pending_q <= pending_d;
      emitted_q <= emitted_d;
      newline_q <= newline_d;
      total_q   <= total_d;
    end
  end

endmodule

// ===== design/atsf_out.sv =====
module atsf_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  atsf_pkg::batch_t batch_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // result_code, kept_count
  output logic             m_axis_tlast   // is_terminator
);
  import atsf_pkg::*;

  res_t [NumSlots-1:0] slot_q;
  logic [1:0]          rem_q, rem_d;
  logic [1:0]          idx_q, idx_d;
  res_t                cur;
  logic                pop;

  assign cur           = slot_q[idx_q];
  assign m_axis_tvalid = (rem_q != 2'd0);
  assign m_axis_tdata  = {cur.count, cur.code};
  assign m_axis_tlast  = cur.term;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign free_o        = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_axis_tready);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load_i) begin
      rem_d = batch_i.cnt;
      idx_d = 2'd0;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      // keep the index inside the slots once the batch drains
      idx_d = (rem_q == 2'd1) ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= batch_i.slot;
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'd3)
    else $error("result index runs past the batch");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> rem_q == 2'd1)
    else $error("terminator is not the last result of its batch");

  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> cur.count == 32'd0)
    else $error("character result carries a count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("batch loaded over undelivered results");

endmodule

// ===== design/arabic_text_skim_filter.sv =====
// an accepted item is held in the input stage register, then its results are
// loaded into the result buffer; throughput: one item per cycle while each
// item gives at most one result and m_axis_tready is high; the single result
// port limits that rate, and an item gives up to three results, one at a time
// reset: asynchronous, clears the input stage, the result buffer and the
// spacing and count state, so the first item starts a new string
module arabic_text_skim_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_code, kept_count
  output logic        m_axis_tlast    // is_terminator
);
  import atsf_pkg::*;

  logic   free;
  logic   load;
  batch_t batch;

  atsf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_code_i  (s_axis_tdata),
    .in_eot_i   (s_axis_tlast),
    .free_i     (free),
    .load_o     (load),
    .batch_o    (batch)
  );

  atsf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .batch_i       (batch),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
